[design/byte_ring_fifo_burst_drain_defines.svh]
// assertion macros for the byte ring fifo checker
`ifndef BYTE_RING_FIFO_BURST_DRAIN_DEFINES_SVH
`define BYTE_RING_FIFO_BURST_DRAIN_DEFINES_SVH

// same-cycle implication
`define BRFD_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("brfd check failed");

// next-cycle implication
`define BRFD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("brfd check failed");

`endif

[design/brfd_pkg.sv]
// shared types and constants of the byte ring fifo
`default_nettype none

package brfd_pkg;

   localparam int MAX_RESULTS = 32;

   typedef enum logic [2:0] {
      OP_PUSH  = 3'd0,
      OP_POP   = 3'd1,
      OP_BURST = 3'd2,
      OP_DRAIN = 3'd3,
      OP_CLEAR = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

endpackage

`default_nettype wire

[design/brfd_ram.sv]
// generic single-port-write ram with registered read
`default_nettype none

module brfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/byte_ring_fifo_burst_drain.sv]
// top level of the byte ring fifo with burst pop and drain
//
// Byte FIFO held in a DEPTH-entry ring memory; csr_data sets how many entries
// are in use (0 acts as 1, above DEPTH acts as DEPTH) and a write to it empties
// the FIFO. Push, clear, an unknown operation and any pop that moves no byte
// each give one result. A pop, burst pop or drain that moves n bytes (n at most
// 32) gives n results: the first byte comes from the registered read of the ring
// memory, then one byte per cycle from the single read port while the output
// register is free. One item is worked on at a time; a finished result waits in
// the output register, and the next item is taken no earlier than the cycle in
// which the last result of the previous item is accepted. Every result carries
// the level and the full and empty flags after it, and tlast marks the final
// result of an item.
`default_nettype none

module byte_ring_fifo_burst_drain #(
   parameter int DEPTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // operation[2:0], push_byte[10:3], burst_len[16:11], zero[23:17]
   input  wire logic [23:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // pop_byte[7:0], status[9:8], taken[15:10], level[21:16], is_full[22], is_empty[23]
   output logic      [23:0] rsp_tdata,
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [5:0]  csr_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic {S_IDLE, S_POP} state_type;

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [5:0]       taken_ff, taken_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [23:0]      rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             out_free;
   logic             req_acc;
   logic             csr_acc;
   logic [2:0]       req_op;
   logic [7:0]       req_byte;
   logic [5:0]       req_burst;
   logic [6:0]       cap_req;
   logic [6:0]       want;
   logic [6:0]       pop_n;

   logic             load;
   logic [7:0]       ld_byte;
   brfd_pkg::status_type ld_status;
   logic             ld_last;
   logic [5:0]       ld_taken;
   logic [CNT_W-1:0] ld_level;
   logic             ld_full;
   logic             ld_empty;

   logic             ram_we;
   logic             ram_re;
   logic [7:0]       ram_rdata;

   function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p,
                                                  input logic [CNT_W-1:0] cap);
      logic [7:0] n;
      n = 8'(p) + 8'd1;
      return (n >= 8'(cap)) ? '0 : PTR_W'(n);
   endfunction

   assign req_op    = req_tdata[2:0];
   assign req_byte  = req_tdata[10:3];
   assign req_burst = req_tdata[16:11];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = (state_ff == S_IDLE);
   assign csr_acc    = csr_valid && csr_ready;

   always_comb begin
      cap_req = (csr_data == 6'd0) ? 7'd1 : 7'(csr_data);
      if (cap_req > 7'(DEPTH)) begin
         cap_req = 7'(DEPTH);
      end
   end

   always_comb begin
      case (req_op)
         brfd_pkg::OP_POP:   want = 7'd1;
         brfd_pkg::OP_BURST: want = (7'(req_burst) > 7'(brfd_pkg::MAX_RESULTS)) ?
                                    7'(brfd_pkg::MAX_RESULTS) : 7'(req_burst);
         default:            want = 7'(brfd_pkg::MAX_RESULTS);
      endcase
      pop_n = (want > 7'(occ_ff)) ? 7'(occ_ff) : want;
   end

   always_comb begin
      state_in  = state_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      occ_in    = occ_ff;
      cap_in    = cap_ff;
      cnt_in    = cnt_ff;
      taken_in  = taken_ff;
      load      = 1'b0;
      ld_byte   = 8'd0;
      ld_status = brfd_pkg::ST_DONE;
      ld_last   = 1'b1;
      ld_taken  = 6'd0;
      ld_level  = occ_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;

      if (csr_acc) begin
         cap_in    = CNT_W'(cap_req);
         wr_ptr_in = '0;
         rd_ptr_in = '0;
         occ_in    = '0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               load = 1'b1;
               case (req_op)
                  brfd_pkg::OP_PUSH: begin
                     if (occ_ff >= cap_ff) begin
                        ld_status = brfd_pkg::ST_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        wr_ptr_in = wrap_next(wr_ptr_ff, cap_ff);
                        occ_in    = occ_ff + CNT_W'(1);
                        ld_level  = occ_ff + CNT_W'(1);
                     end
                  end
                  brfd_pkg::OP_POP, brfd_pkg::OP_BURST, brfd_pkg::OP_DRAIN: begin
                     if (pop_n == 7'd0) begin
                        ld_status = (occ_ff == '0) ? brfd_pkg::ST_EMPTY : brfd_pkg::ST_DONE;
                     end else begin
                        load      = 1'b0;
                        ram_re    = 1'b1;
                        rd_ptr_in = wrap_next(rd_ptr_ff, cap_ff);
                        cnt_in    = 6'(pop_n);
                        taken_in  = 6'd0;
                        state_in  = S_POP;
                     end
                  end
                  brfd_pkg::OP_CLEAR: begin
                     wr_ptr_in = '0;
                     rd_ptr_in = '0;
                     occ_in    = '0;
                     ld_level  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP: begin
            if (out_free) begin
               load     = 1'b1;
               ld_byte  = ram_rdata;
               ld_taken = taken_ff + 6'd1;
               ld_level = occ_ff - CNT_W'(1);
               ld_last  = (taken_ff + 6'd1 == cnt_ff);
               occ_in   = occ_ff - CNT_W'(1);
               taken_in = taken_ff + 6'd1;
               if (ld_last) begin
                  state_in = S_IDLE;
               end else begin
                  ram_re    = 1'b1;
                  rd_ptr_in = wrap_next(rd_ptr_ff, cap_ff);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign ld_full  = (ld_level >= cap_ff);
   assign ld_empty = (ld_level == '0);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {ld_empty, ld_full, 6'(ld_level), ld_taken, ld_status, ld_byte};
         rsp_last_in  = ld_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         occ_ff       <= '0;
         cap_ff       <= CNT_W'(DEPTH);
         cnt_ff       <= 6'd0;
         taken_ff     <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         occ_ff       <= occ_in;
         cap_ff       <= cap_in;
         cnt_ff       <= cnt_in;
         taken_ff     <= taken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   brfd_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_byte),
      .rd_en   (ram_re),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

[design/brfd_checker.sv]
// port-level checks of the byte ring fifo result stream
`default_nettype none

`include "byte_ring_fifo_burst_drain_defines.svh"

module brfd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   `BRFD_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   `BRFD_ASSERT_NOW(a_flags_excl, rsp_tvalid, !(rsp_tdata[22] && rsp_tdata[23]))

   `BRFD_ASSERT_NOW(a_empty_level, rsp_tvalid && rsp_tdata[23], rsp_tdata[21:16] == 6'd0)

   `BRFD_ASSERT_NOW(a_fail_single, rsp_tvalid && rsp_tdata[9:8] != brfd_pkg::ST_DONE, rsp_tlast && rsp_tdata[15:10] == 6'd0 && rsp_tdata[7:0] == 8'd0)

   `BRFD_ASSERT_NOW(a_mid_burst, rsp_tvalid && !rsp_tlast, rsp_tdata[9:8] == brfd_pkg::ST_DONE && rsp_tdata[15:10] != 6'd0)

endmodule

bind byte_ring_fifo_burst_drain brfd_checker u_brfd_checker (.*);

`default_nettype wire
